>>> design/twa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package twa_pkg;

    typedef enum logic [1:0] {
        MODE_AUTO   = 2'd0,
        MODE_FRAMED = 2'd1,
        MODE_TEXT   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_MID  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        PFX_NONE = 2'd0,
        PFX_ESC  = 2'd1,
        PFX_IAC  = 2'd2
    } prefix_t;

    localparam logic [6:0]  ESC_CODE   = 7'o033;
    localparam logic [7:0]  IAC_CODE   = 8'o377;
    localparam logic [19:0] DELAY_WORD = 20'h80000;
    localparam logic [11:0] ESC_HIGH   = 12'h01B;
    localparam int          QDEPTH     = 2;
    localparam int          QPTR_W     = $clog2(QDEPTH);

    // One queue entry: a single byte, or the three held bytes of a format probe.
    typedef struct packed {
        logic            replay;
        logic            framed;
        logic [2:0][7:0] bytes;
    } q_entry_t;

    typedef struct packed {
        logic    push;
        q_entry_t entry;
    } q_push_t;

    typedef struct packed {
        phase_t     phase;
        logic [6:0] high;
        logic [5:0] mid;
        prefix_t    prefix;
    } feed_st_t;

    typedef struct packed {
        feed_st_t    st;
        logic        hit;
        logic [19:0] word;
    } feed_res_t;

    function automatic mode_t mode_of(logic [1:0] sel);
        mode_t m;
        case (sel)
            MODE_FRAMED: m = MODE_FRAMED;
            MODE_TEXT:   m = MODE_TEXT;
            default:     m = MODE_AUTO;
        endcase
        return m;
    endfunction

    function automatic feed_res_t twa_feed(feed_st_t st, logic framed, logic [7:0] b);
        feed_res_t  r;
        logic [6:0] c;
        r      = '0;
        r.st   = st;
        c      = b[6:0];
        if (framed) begin
            case (st.phase)
                PH_HIGH:
                begin
                    if (b[7:6] == 2'b10) begin
                        r.st.mid   = b[5:0];
                        r.st.phase = PH_MID;
                    end else if (!b[7]) begin
                        r.st.high = c;
                    end else begin
                        r.st.phase = PH_IDLE;
                    end
                end
                PH_MID:
                begin
                    if (b[7:6] == 2'b11) begin
                        r.hit      = 1'b1;
                        r.word     = {1'b0, st.high, st.mid, b[5:0]};
                        r.st.phase = PH_IDLE;
                    end else if (!b[7]) begin
                        r.st.high  = c;
                        r.st.phase = PH_HIGH;
                    end else begin
                        r.st.phase = PH_IDLE;
                    end
                end
                default:
                begin
                    if (!b[7]) begin
                        r.st.high  = c;
                        r.st.phase = PH_HIGH;
                    end else begin
                        r.st.phase = PH_IDLE;
                    end
                end
            endcase
        end else begin
            if (st.prefix == PFX_NONE && b == IAC_CODE) begin
                r.st.prefix = PFX_IAC;
            end else if (c == ESC_CODE) begin
                r.st.prefix = PFX_ESC;
            end else if (st.prefix == PFX_ESC) begin
                r.st.prefix = PFX_NONE;
                r.hit       = 1'b1;
                r.word      = {ESC_HIGH, 1'b0, c};
            end else begin
                r.st.prefix = PFX_NONE;
                r.hit       = 1'b1;
                r.word      = (c == 7'd0) ? DELAY_WORD : {13'd0, c};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/terminal_word_assembler_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Path: an accepted byte is written into the queue, then decoded into the output
// slot registers, from which its first word is shown. Throughput: one byte per cycle
// while in_stall is low; a format probe releases its held three bytes as up to three
// words on consecutive cycles, paced by the one-word output port.
// A two-entry queue separates byte intake from decoding, so each side stalls alone.
// Reset (rst_n low, asynchronous) selects auto-detect and clears all progress.

module terminal_word_assembler_core
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_data,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [7:0]  data_byte,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [19:0] word,
    output logic        last_of_run
);

    twa_pkg::q_push_t  q_push;
    twa_pkg::q_entry_t q_head;
    logic              q_full, q_valid, q_pop;
    logic              cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid;

    twa_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .q_full    (q_full),
        .data_byte (data_byte),
        .in_stall  (in_stall),
        .q_push    (q_push)
    );

    twa_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_push    (q_push),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (q_head)
    );

    twa_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr      (cfg_wr),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .word        (word),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire

>>> design/twa_front.sv
`timescale 1ns / 1ps
`default_nettype none

module twa_front
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire               cfg_wr,
    input  wire [1:0]         cfg_data,
    input  wire               in_valid,
    input  wire               q_full,
    input  wire [7:0]         data_byte,
    output logic              in_stall,
    output twa_pkg::q_push_t  q_push
);

    twa_pkg::mode_t decided_reg, decided_next;
    logic [1:0]     probe_count_reg, probe_count_next;
    logic [7:0]     probe0_reg, probe0_next;
    logic [7:0]     probe1_reg, probe1_next;
    logic           accept;
    logic           frame_ok;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // The third probe byte is the one arriving now; it completes the check.
    assign frame_ok = !probe0_reg[7] && (probe1_reg[7:6] == 2'b10)
                      && (data_byte[7:6] == 2'b11);

    always_comb
    begin
        decided_next     = decided_reg;
        probe_count_next = probe_count_reg;
        probe0_next      = probe0_reg;
        probe1_next      = probe1_reg;
        q_push           = '0;
        if (cfg_wr) begin
            decided_next     = twa_pkg::mode_of(cfg_data);
            probe_count_next = 2'd0;
        end else if (accept) begin
            if (decided_reg == twa_pkg::MODE_AUTO) begin
                if (probe_count_reg == 2'd0) begin
                    probe0_next      = data_byte;
                    probe_count_next = 2'd1;
                end else if (probe_count_reg == 2'd1) begin
                    probe1_next      = data_byte;
                    probe_count_next = 2'd2;
                end else begin
                    probe_count_next     = 2'd0;
                    decided_next         = frame_ok ? twa_pkg::MODE_FRAMED
                                                    : twa_pkg::MODE_TEXT;
                    q_push.push          = 1'b1;
                    q_push.entry.replay  = 1'b1;
                    q_push.entry.framed  = frame_ok;
                    q_push.entry.bytes   = {data_byte, probe1_reg, probe0_reg};
                end
            end else begin
                q_push.push         = 1'b1;
                q_push.entry.replay = 1'b0;
                q_push.entry.framed = (decided_reg == twa_pkg::MODE_FRAMED);
                q_push.entry.bytes  = {16'd0, data_byte};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            decided_reg     <= twa_pkg::MODE_AUTO;
            probe_count_reg <= 2'd0;
        end else begin
            decided_reg     <= decided_next;
            probe_count_reg <= probe_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        probe0_reg <= probe0_next;
        probe1_reg <= probe1_next;
    end

endmodule

`default_nettype wire

>>> design/twa_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module twa_queue
(
    input  wire                clk,
    input  wire                rst_n,
    input  twa_pkg::q_push_t   q_push,
    input  wire                pop,
    output logic               full,
    output logic               not_empty,
    output twa_pkg::q_entry_t  head
);

    localparam int CNT_W = $clog2(twa_pkg::QDEPTH + 1);

    twa_pkg::q_entry_t                mem [twa_pkg::QDEPTH];
    logic [twa_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [twa_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic                             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(twa_pkg::QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];
    assign do_push   = q_push.push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == twa_pkg::QPTR_W'(twa_pkg::QDEPTH - 1))
                          ? '0 : twa_pkg::QPTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == twa_pkg::QPTR_W'(twa_pkg::QDEPTH - 1))
                          ? '0 : twa_pkg::QPTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop) begin
            count_next = CNT_W'(count_reg + 1'b1);
        end else if (do_pop && !do_push) begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem[wr_ptr_reg] <= q_push.entry;
        end
    end

endmodule

`default_nettype wire

>>> design/twa_back.sv
`timescale 1ns / 1ps
`default_nettype none

module twa_back
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cfg_wr,
    input  wire                q_valid,
    input  twa_pkg::q_entry_t  q_head,
    output logic               q_pop,
    input  wire                out_stall,
    output logic               out_valid,
    output logic [19:0]        word,
    output logic               last_of_run
);

    twa_pkg::feed_st_t  st_reg, st_next;
    logic [19:0]        slot_reg [3];
    logic [19:0]        slot_next [3];
    logic [1:0]         head_reg, head_next;
    logic [1:0]         cnt_reg, cnt_next;
    twa_pkg::feed_res_t r0, r1, r2;
    logic [2:0]         hits;
    logic [19:0]        words [3];
    logic [1:0]         fill;
    logic               take, drain;

    assign out_valid   = (head_reg != cnt_reg);
    assign last_of_run = (2'(head_reg + 2'd1) == cnt_reg);

    always_comb
    begin
        case (head_reg)
            2'd1:    word = slot_reg[1];
            2'd2:    word = slot_reg[2];
            default: word = slot_reg[0];
        endcase
    end

    assign take  = out_valid && !out_stall;
    assign drain = !out_valid || (take && last_of_run);
    assign q_pop = q_valid && drain;

    // A replayed probe runs all three bytes through the decoder in one pass.
    assign r0 = twa_pkg::twa_feed(st_reg, q_head.framed, q_head.bytes[0]);
    assign r1 = twa_pkg::twa_feed(r0.st, q_head.framed, q_head.bytes[1]);
    assign r2 = twa_pkg::twa_feed(r1.st, q_head.framed, q_head.bytes[2]);

    assign hits     = {r2.hit && q_head.replay, r1.hit && q_head.replay, r0.hit};
    assign words[0] = r0.word;
    assign words[1] = r1.word;
    assign words[2] = r2.word;

    always_comb
    begin
        fill = 2'd0;
        for (int i = 0; i < 3; i++) begin
            slot_next[i] = slot_reg[i];
        end
        for (int i = 0; i < 3; i++) begin
            if (hits[i]) begin
                slot_next[fill] = words[i];
                fill            = 2'(fill + 2'd1);
            end
        end
    end

    always_comb
    begin
        st_next   = st_reg;
        head_next = head_reg;
        cnt_next  = cnt_reg;
        if (cfg_wr) begin
            st_next = '0;
        end else if (q_pop) begin
            st_next   = q_head.replay ? r2.st : r0.st;
            head_next = 2'd0;
            cnt_next  = fill;
        end else if (take) begin
            head_next = 2'(head_reg + 2'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg   <= '0;
            head_reg <= 2'd0;
            cnt_reg  <= 2'd0;
        end else begin
            st_reg   <= st_next;
            head_reg <= head_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && !cfg_wr) begin
            for (int i = 0; i < 3; i++) begin
                slot_reg[i] <= slot_next[i];
            end
        end
    end

endmodule

`default_nettype wire

>>> design/twa_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module twa_checker
(
    input wire        clk,
    input wire        rst_n,
    input wire        out_valid,
    input wire        out_stall,
    input wire [19:0] word,
    input wire        last_of_run
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(word) && $stable(last_of_run))
        else $error("stalled output word changed");

    // The delay word carries nothing but its marker bit.
    a_delay_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && word[19] |-> word[18:0] == 19'd0)
        else $error("delay word has stray bits");

    // The rest of a run is already buffered, so it follows without a gap.
    a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run |=> out_valid)
        else $error("gap inside a run of words");

endmodule

bind terminal_word_assembler_core twa_checker u_twa_checker (.*);

`default_nettype wire
